[src/bap_pkg.sv]
// Shared types and constants for the 2x2 block-average pixelator.
package bap_pkg;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_WIDTH_PAIRS  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT_PAIRS = 2'd1;
    localparam int CFG_DATA_W = 10;
    localparam logic [CFG_DATA_W-1:0] PAIRS_RESET = 10'd256;

    // Queue between the front and the back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    typedef struct packed {
        logic [7:0] pixel;
        logic       start_of_frame;
    } bap_pixel_t;

    typedef struct packed {
        logic [8:0] block_row;
        logic [8:0] block_col;
        logic [7:0] mean;
        logic       last_in_frame;
    } bap_block_t;

    // Block waiting for its line-store read
    typedef struct packed {
        logic [8:0] block_row;
        logic [8:0] block_col;
        logic [8:0] pair_sum;
        logic       last_in_frame;
    } bap_job_t;

    // Block with both pair sums, ready for the mean
    typedef struct packed {
        logic [8:0] block_row;
        logic [8:0] block_col;
        logic [8:0] pair_sum;
        logic [8:0] line_sum;
        logic       last_in_frame;
    } bap_entry_t;

    typedef struct packed {
        logic       valid;
        bap_entry_t entry;
    } bap_push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } bap_qstat_t;

endpackage

[src/bap_front.sv]
// Front end: position counters, pair sums, line store and block classification.
module bap_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            pix_valid,
    output logic                            pix_stall,
    input  bap_pkg::bap_pixel_t             pix_word,
    input  logic [bap_pkg::CFG_DATA_W-1:0]  width_pairs,
    input  logic [bap_pkg::CFG_DATA_W-1:0]  height_pairs,
    input  bap_pkg::bap_qstat_t             q_stat,
    output bap_pkg::bap_push_t              push
);
    import bap_pkg::*;

    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int LINE_AW    = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int CW         = LINE_AW + 1;
    localparam int CCMPW      = (CW > CFG_DATA_W) ? CW : CFG_DATA_W;
    localparam int ROW_DEPTH  = MAX_HEIGHT / 2;
    localparam int ROW_AW     = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1;
    localparam int RW         = ROW_AW + 1;
    localparam int RCMPW      = (RW > CFG_DATA_W) ? RW : CFG_DATA_W;

    logic [CW-1:0]    col_reg, col_next, col_cur, col_last;
    logic [RW-1:0]    row_reg, row_next, row_cur, row_last;
    logic [7:0]       partial_reg, partial_next;
    logic             job_valid_reg, job_valid_next;
    bap_job_t         job_reg, job_next;
    logic [8:0]       line_rd_reg;
    logic [8:0]       line_mem [0:LINE_DEPTH-1];
    logic [LINE_AW-1:0] line_addr;
    logic             line_we, line_re;
    logic [8:0]       pair_sum;
    logic             accept;
    logic [CCMPW-1:0] w_ext, w_clamp, w_m1;
    logic [RCMPW-1:0] h_ext, h_clamp, h_m1;
    logic [LINE_AW+8:0] col_ext;
    logic [ROW_AW+8:0]  row_ext;

    // Clamp the dimensions to 1..limit and form the last column and row
    always_comb
    begin
        w_ext = CCMPW'(width_pairs);
        if (w_ext == '0)
            w_clamp = CCMPW'(1);
        else if (w_ext > CCMPW'(LINE_DEPTH))
            w_clamp = CCMPW'(LINE_DEPTH);
        else
            w_clamp = w_ext;
        w_m1     = w_clamp - CCMPW'(1);
        col_last = {w_m1[LINE_AW-1:0], 1'b1};

        h_ext = RCMPW'(height_pairs);
        if (h_ext == '0)
            h_clamp = RCMPW'(1);
        else if (h_ext > RCMPW'(ROW_DEPTH))
            h_clamp = RCMPW'(ROW_DEPTH);
        else
            h_clamp = h_ext;
        h_m1     = h_clamp - RCMPW'(1);
        row_last = {h_m1[ROW_AW-1:0], 1'b1};
    end

    // Hold the input while a finished block cannot enter the queue
    assign pix_stall = job_valid_reg & q_stat.full;
    assign accept    = pix_valid & ~pix_stall;

    always_comb
    begin
        col_cur   = pix_word.start_of_frame ? '0 : col_reg;
        row_cur   = pix_word.start_of_frame ? '0 : row_reg;
        line_addr = col_cur[LINE_AW:1];
        pair_sum  = {1'b0, partial_reg} + {1'b0, pix_word.pixel};
        col_ext   = {{9{1'b0}}, col_cur[LINE_AW:1]};
        row_ext   = {{9{1'b0}}, row_cur[ROW_AW:1]};

        line_we        = 1'b0;
        line_re        = 1'b0;
        partial_next   = partial_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        job_valid_next = job_valid_reg & q_stat.full;

        job_next.block_row     = row_ext[8:0];
        job_next.block_col     = col_ext[8:0];
        job_next.pair_sum      = pair_sum;
        job_next.last_in_frame = (row_cur == row_last) && (col_cur == col_last);

        if (accept)
        begin
            job_valid_next = 1'b0;
            if (!col_cur[0])
                partial_next = pix_word.pixel;
            else if (!row_cur[0])
                line_we = 1'b1;
            else
            begin
                line_re        = 1'b1;
                job_valid_next = 1'b1;
            end

            // Advance the raster position, wrapping at row and frame end
            if (col_cur >= col_last)
            begin
                col_next = '0;
                if (row_cur >= row_last)
                    row_next = '0;
                else
                    row_next = row_cur + RW'(1);
            end
            else
            begin
                col_next = col_cur + CW'(1);
                row_next = row_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            partial_reg   <= '0;
            job_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            partial_reg   <= partial_next;
            job_valid_reg <= job_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (line_re)
            job_reg <= job_next;
    end

    // Line store of even-row pair sums
    always_ff @(posedge clk)
    begin
        if (line_we)
            line_mem[line_addr] <= pair_sum;
        if (line_re)
            line_rd_reg <= line_mem[line_addr];
    end

    assign push.valid               = job_valid_reg & ~q_stat.full;
    assign push.entry.block_row     = job_reg.block_row;
    assign push.entry.block_col     = job_reg.block_col;
    assign push.entry.pair_sum      = job_reg.pair_sum;
    assign push.entry.line_sum      = line_rd_reg;
    assign push.entry.last_in_frame = job_reg.last_in_frame;

endmodule

[src/bap_queue.sv]
// Short queue of finished blocks between the front and the back.
module bap_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bap_pkg::bap_push_t   push,
    input  logic                 pop,
    output bap_pkg::bap_entry_t  head,
    output bap_pkg::bap_qstat_t  q_stat
);
    import bap_pkg::*;

    bap_entry_t            slot_mem [0:QUEUE_DEPTH-1];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_AW:0]     count_reg, count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push.valid && !pop)
            count_next = count_reg + (QUEUE_AW+1)'(1);
        else if (!push.valid && pop)
            count_next = count_reg - (QUEUE_AW+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push.valid)
                wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
            slot_mem[wr_ptr_reg] <= push.entry;
    end

    assign head         = slot_mem[rd_ptr_reg];
    assign q_stat.full  = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);

endmodule

[src/bap_back.sv]
// Back end: forms the block mean and holds it in the output register.
module bap_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bap_pkg::bap_entry_t  head,
    input  bap_pkg::bap_qstat_t  q_stat,
    output logic                 pop,
    output logic                 blk_valid,
    input  logic                 blk_stall,
    output bap_pkg::bap_block_t  blk_word
);
    import bap_pkg::*;

    logic       blk_valid_reg, blk_valid_next;
    bap_block_t blk_word_reg, blk_word_next;
    logic [9:0] sum;

    // Take the next block when the output register is empty or being taken
    assign pop = ~q_stat.empty & (~blk_valid_reg | ~blk_stall);

    always_comb
    begin
        sum = {1'b0, head.pair_sum} + {1'b0, head.line_sum};
        blk_word_next.block_row     = head.block_row;
        blk_word_next.block_col     = head.block_col;
        blk_word_next.mean          = sum[9:2];
        blk_word_next.last_in_frame = head.last_in_frame;

        blk_valid_next = blk_valid_reg & blk_stall;
        if (pop)
            blk_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            blk_valid_reg <= 1'b0;
        else
            blk_valid_reg <= blk_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            blk_word_reg <= blk_word_next;
    end

    assign blk_valid = blk_valid_reg;
    assign blk_word  = blk_word_reg;

endmodule

[src/block_average_pixelate_2x2.sv]
// Top level of the 2x2 block-average pixelator.
// Grey pixels enter in raster order at one per clock while not stalled; every 2x2
// block yields one word with its block position, the floor of the mean of its four
// pixels and a flag on the frame's last block, sent when the block's bottom-right
// pixel arrives. A block word then passes through the line-store read register, the
// four-word queue and the output register. The input stalls only once the queue is
// full and a further block is waiting to enter it. width_pairs and height_pairs give
// the image size in 2x2 blocks; 0 counts as 1 and values above MAX_WIDTH/2 or
// MAX_HEIGHT/2 saturate. start_of_frame restarts the counters at the top-left pixel.
module block_average_pixelate_2x2 #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              pix_valid,
    output logic                              pix_stall,
    input  bap_pkg::bap_pixel_t               pix_word,
    output logic                              blk_valid,
    input  logic                              blk_stall,
    output bap_pkg::bap_block_t               blk_word,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bap_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bap_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import bap_pkg::*;

    logic [CFG_DATA_W-1:0] width_pairs_reg, height_pairs_reg;
    bap_push_t             push;
    bap_qstat_t            q_stat;
    bap_entry_t            head;
    logic                  pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_pairs_reg  <= PAIRS_RESET;
            height_pairs_reg <= PAIRS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_WIDTH_PAIRS:  width_pairs_reg  <= cfg_data;
                REG_HEIGHT_PAIRS: height_pairs_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    bap_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .pix_valid    (pix_valid),
        .pix_stall    (pix_stall),
        .pix_word     (pix_word),
        .width_pairs  (width_pairs_reg),
        .height_pairs (height_pairs_reg),
        .q_stat       (q_stat),
        .push         (push)
    );

    bap_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .pop    (pop),
        .head   (head),
        .q_stat (q_stat)
    );

    bap_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_stat    (q_stat),
        .pop       (pop),
        .blk_valid (blk_valid),
        .blk_stall (blk_stall),
        .blk_word  (blk_word)
    );

    a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue reports full and empty at once");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> !q_stat.full)
        else $error("push into a full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("pop from an empty queue");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        pix_stall |-> q_stat.full)
        else $error("input stalled while the queue has room");

endmodule

[sim/tb_top.sv]
// Self-checking testbench for the 2x2 block-average pixelator.
`timescale 1ns / 100ps

module tb_top;

    import bap_pkg::*;

    localparam int MAX_PAIRS  = 512;
    localparam int LINE_SLOTS = 512;
    localparam int DRAIN_GAP  = 8;
    localparam int HOLD_LEN   = 80;

    // Running model of the pixelator: counters, line store and expected block words
    class block_mean_board;
        bap_block_t     pending_blocks[$];
        int             errors;
        logic [9:0]     width_reg;
        logic [9:0]     height_reg;
        int             col;
        int             row;
        int             held_pixel;
        int             line_sums[LINE_SLOTS];
        bit             line_filled[LINE_SLOTS];

        function new();
            errors     = 0;
            width_reg  = PAIRS_RESET;
            height_reg = PAIRS_RESET;
            col        = 0;
            row        = 0;
            held_pixel = 0;
        endfunction

        function int eff_pairs(logic [9:0] v);
            if (v == 0)
                return 1;
            if (v > MAX_PAIRS)
                return MAX_PAIRS;
            return int'(v);
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_WIDTH_PAIRS)
                width_reg = data;
            else if (idx == REG_HEIGHT_PAIRS)
                height_reg = data;
        endfunction

        // True when the next word, sent without a frame start, would hit an empty line slot
        function bit would_read_blank();
            return (col % 2 == 1) && (row % 2 == 1) && !line_filled[(col >> 1) % LINE_SLOTS];
        endfunction

        function void take_pixel(bap_pixel_t w);
            int         pw;
            int         ph;
            int         idx;
            int         sum;
            bap_block_t b;
            pw = 2 * eff_pairs(width_reg);
            ph = 2 * eff_pairs(height_reg);
            if (w.start_of_frame)
            begin
                col = 0;
                row = 0;
            end
            idx = (col >> 1) % LINE_SLOTS;
            if (col % 2 == 0)
                held_pixel = int'(w.pixel);
            else if (row % 2 == 0)
            begin
                line_sums[idx]   = (held_pixel + int'(w.pixel)) & 'h1FF;
                line_filled[idx] = 1'b1;
            end
            else
            begin
                sum             = line_sums[idx] + held_pixel + int'(w.pixel);
                b.block_row     = 9'((row >> 1) & 'h1FF);
                b.block_col     = 9'((col >> 1) & 'h1FF);
                b.mean          = 8'((sum / 4) & 'hFF);
                b.last_in_frame = (row == ph - 1) && (col == pw - 1);
                pending_blocks.push_back(b);
            end
            col++;
            if (col >= pw)
            begin
                col = 0;
                row++;
                if (row >= ph)
                    row = 0;
            end
        endfunction

        function void check_field(string name, logic [8:0] want, logic [8:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        function void match_block(bap_block_t got);
            bap_block_t want;
            if (pending_blocks.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected block word, expected none, got %h", $time, got);
                return;
            end
            want = pending_blocks.pop_front();
            check_field("block_row", want.block_row, got.block_row);
            check_field("block_col", want.block_col, got.block_col);
            check_field("mean", 9'(want.mean), 9'(got.mean));
            check_field("last_in_frame", 9'(want.last_in_frame), 9'(got.last_in_frame));
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   pix_valid = 1'b0;
    logic                   pix_stall;
    bap_pixel_t             pix_word = '0;
    logic                   blk_valid;
    logic                   blk_stall = 1'b0;
    bap_block_t             blk_word;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    int                     send_idle_pct = 0;
    int                     recv_idle_pct = 0;
    int                     stall_hold = 0;

    block_mean_board        sb = new();

    block_average_pixelate_2x2 u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_word  (pix_word),
        .blk_valid (blk_valid),
        .blk_stall (blk_stall),
        .blk_word  (blk_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // Receiver: random stalls, or a long hold when one is requested
    always @(negedge clk)
    begin
        if (stall_hold > 0)
        begin
            blk_stall <= 1'b1;
            stall_hold--;
        end
        else
            blk_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && blk_valid && !blk_stall)
            sb.match_block(blk_word);
    end

    initial
    begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end

    // Entered and left just after a falling edge
    task automatic send_pixel(input logic [7:0] px, input logic sof);
        bap_pixel_t w;
        w.pixel          = px;
        w.start_of_frame = sof | sb.would_read_blank();
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            pix_valid <= 1'b0;
            @(negedge clk);
        end
        pix_valid <= 1'b1;
        pix_word  <= w;
        do
            @(posedge clk);
        while (pix_stall);
        sb.take_pixel(w);
        @(negedge clk);
    endtask

    task automatic drain();
        pix_valid <= 1'b0;
        while (sb.pending_blocks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_GAP) @(posedge clk);
        @(negedge clk);
    endtask

    // Write both size registers, keeping valid high across the two words
    task automatic write_dims(input logic [9:0] wp, input logic [9:0] hp);
        cfg_valid <= 1'b1;
        cfg_index <= REG_WIDTH_PAIRS;
        cfg_data  <= wp;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_reg(REG_WIDTH_PAIRS, wp);
        @(negedge clk);
        cfg_index <= REG_HEIGHT_PAIRS;
        cfg_data  <= hp;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_reg(REG_HEIGHT_PAIRS, hp);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_frame_run(input int count);
        send_pixel(8'($urandom), 1'b1);
        repeat (count - 1) send_pixel(8'($urandom), 1'b0);
    endtask

    initial
    begin
        logic [7:0] frame_px[25];
        bit         frame_sof[25];
        int         n_items;
        logic [9:0] wp;
        logic [9:0] hp;

        frame_px  = '{255, 255, 0, 0, 255, 255, 0, 0,
                      1, 2, 0, 255, 3, 4, 255, 254,
                      10, 20, 30, 40, 50, 60, 70, 80, 90};
        frame_sof = '{default: 1'b0};
        frame_sof[0]  = 1'b1;
        frame_sof[19] = 1'b1;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 17;
        recv_idle_pct = 71;

        // 4x4 frame: full-white and black blocks, a rounding block, the last block,
        // then a restart part-way through a row
        write_dims(10'd2, 10'd2);
        foreach (frame_px[i])
            send_pixel(frame_px[i], frame_sof[i]);
        drain();

        for (int k = 0; k < 12; k++)
        begin
            if (k == 4)
            begin
                send_idle_pct = 71;
                recv_idle_pct = 17;
            end
            else if (k == 8)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            wp = ($urandom_range(7) == 0) ? 10'd0 : 10'($urandom_range(1, 6));
            hp = ($urandom_range(7) == 0) ? 10'd0 : 10'($urandom_range(1, 5));
            write_dims(wp, hp);
            if (k == 9)
                stall_hold = HOLD_LEN;
            // Long enough under the hold to fill the queue and stall the input
            n_items = (k == 9) ? 60 : $urandom_range(16, 32);
            // Mostly start clean; otherwise carry on mid-frame under the new size
            send_pixel(8'($urandom), $urandom_range(3) != 0);
            repeat (n_items - 1)
                send_pixel(8'($urandom), $urandom_range(49) == 0);
            drain();
        end

        // Oversized width, one block high: run a little into the second row, where the
        // saturated width sets the wrap
        write_dims(10'd1023, 10'd0);
        send_frame_run(1032);
        drain();

        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
